// ===== rtl/fh64_pkg.sv =====
package fh64_pkg;

  localparam logic [63:0] HASH_MULT   = 64'h8803_55f2_1e6d_1965;
  localparam logic [63:0] MIX_MULT    = 64'h2127_599b_f432_5c37;
  localparam logic [63:0] SEED_RESET  = 64'h0000_0000_04C1_1DB7;
  localparam int unsigned MIX_SHIFT_A = 23;
  localparam int unsigned MIX_SHIFT_B = 47;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  valid_bytes;
    logic        last;
    logic [31:0] message_length;
  } fh64_in_t;

  typedef struct packed {
    logic [63:0] hash64;
    logic [31:0] hash32;
  } fh64_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } fh64_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } fh64_mul_rsp_t;

endpackage

// ===== rtl/fasthash64_stream_hasher_unit.sv =====
// Each 64-bit product runs through one shared 32x32 multiplier in three partial
// products; n = 0..4 products per word (length, word mix, accumulator, final mix).
// src_stall stays high while a word's products run and, for a last word, until its
// result is registered. The registered result is taken from the final mix through the
// S_EMIT state; a result held by dst_stall makes the next one wait and stall input.
// Synchronous active-high reset: seed to 0x04C11DB7, accumulator cleared, no message open.
module fasthash64_stream_hasher_unit import fh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  fh64_in_t    src_data,
  output logic        dst_valid,
  input  logic        dst_stall,
  output fh64_out_t   dst_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_MIX,
    S_ACC,
    S_FIN,
    S_EMIT
  } state_t;

  state_t        state;
  logic [63:0]   seed;
  logic [63:0]   acc;
  logic          in_message;
  logic [63:0]   v;
  logic          nz;
  logic          last;
  fh64_mul_req_t req;
  fh64_mul_rsp_t rsp;
  logic [63:0]   mask_in;
  logic [63:0]   v_in;
  logic          nz_in;
  logic [63:0]   acc_init;
  logic [63:0]   mixed;

  fh64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask_in[i*8 +: 8] = (4'(i) < src_data.valid_bytes) ? 8'hff : 8'h00;
    end
  end

  assign v_in      = src_data.word & mask_in;
  assign nz_in     = (src_data.valid_bytes != 4'd0);
  assign acc_init  = seed ^ rsp.p;
  assign mixed     = rsp.p ^ (rsp.p >> MIX_SHIFT_B);
  assign src_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed       <= SEED_RESET;
      acc        <= 64'h0;
      in_message <= 1'b0;
      req.start  <= 1'b0;
      dst_valid  <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (cfg_valid) begin
        seed <= cfg_data;
      end
      if (dst_valid && !dst_stall) begin
        dst_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (src_valid) begin
            v    <= v_in;
            nz   <= nz_in;
            last <= src_data.last;
            if (!in_message) begin
              req.start <= 1'b1;
              req.a     <= {32'h0, src_data.message_length};
              req.b     <= HASH_MULT;
              state     <= S_INIT;
            end else if (nz_in) begin
              req.start <= 1'b1;
              req.a     <= v_in ^ (v_in >> MIX_SHIFT_A);
              req.b     <= MIX_MULT;
              state     <= S_MIX;
            end else if (src_data.last) begin
              req.start <= 1'b1;
              req.a     <= acc ^ (acc >> MIX_SHIFT_A);
              req.b     <= MIX_MULT;
              state     <= S_FIN;
            end
          end
        end
        S_INIT: begin
          if (rsp.done) begin
            acc <= acc_init;
            if (nz) begin
              req.start <= 1'b1;
              req.a     <= v ^ (v >> MIX_SHIFT_A);
              req.b     <= MIX_MULT;
              state     <= S_MIX;
            end else if (last) begin
              req.start <= 1'b1;
              req.a     <= acc_init ^ (acc_init >> MIX_SHIFT_A);
              req.b     <= MIX_MULT;
              state     <= S_FIN;
            end else begin
              in_message <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        S_MIX: begin
          if (rsp.done) begin
            req.start <= 1'b1;
            req.a     <= acc ^ mixed;
            req.b     <= HASH_MULT;
            state     <= S_ACC;
          end
        end
        S_ACC: begin
          if (rsp.done) begin
            acc <= rsp.p;
            if (last) begin
              req.start <= 1'b1;
              req.a     <= rsp.p ^ (rsp.p >> MIX_SHIFT_A);
              req.b     <= MIX_MULT;
              state     <= S_FIN;
            end else begin
              in_message <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!dst_valid || !dst_stall) begin
            dst_valid       <= 1'b1;
            dst_data.hash64 <= mixed;
            dst_data.hash32 <= mixed[31:0] - mixed[63:32];
            in_message      <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fh64_mul.sv =====
module fh64_mul import fh64_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  fh64_mul_req_t req,
  output fh64_mul_rsp_t rsp
);

  logic        busy;
  logic [1:0]  cnt;
  logic        done;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] pp;
  logic [63:0] sum;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // low x low, low x high, high x low; only the low 64 bits are kept
  assign op_a = (cnt == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign op_b = (cnt == 2'd1) ? b_r[63:32] : b_r[31:0];
  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
        a_r  <= req.a;
        b_r  <= req.b;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        case (cnt)
          2'd0: pp <= prod;
          2'd1: begin
            pp  <= prod;
            sum <= pp;
          end
          2'd2: begin
            pp  <= prod;
            sum <= sum + {pp[31:0], 32'h0};
          end
          default: begin
            sum  <= sum + {pp[31:0], 32'h0};
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = sum;

endmodule

// ===== verif/fasthash64_stream_hasher_unit_tb.sv =====
`timescale 1ns / 1ps

module fasthash64_stream_hasher_unit_tb import fh64_pkg::*;;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 650;
  localparam int SEED_INTERVAL  = 150;

  logic        clk;
  logic        rst;
  logic        src_valid;
  logic        src_stall;
  fh64_in_t    src_data;
  logic        dst_valid;
  logic        dst_stall;
  fh64_out_t   dst_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  logic [63:0] seed_q;
  logic [63:0] acc_q;
  logic        msg_open;
  fh64_out_t   hash_q[$];
  fh64_out_t   hash_exp;

  int errors;
  int items_sent;
  int idle_cycles;
  int rx_stall_left;
  int rx_gap;
  bit tx_gaps;
  bit rx_gaps;
  bit rx_hold;

  fasthash64_stream_hasher_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] fold_mix(logic [63:0] x);
    x = x ^ (x >> MIX_SHIFT_A);
    x = x * MIX_MULT;
    x = x ^ (x >> MIX_SHIFT_B);
    return x;
  endfunction

  function automatic void absorb_word(fh64_in_t it);
    logic [3:0]  nb;
    logic [63:0] mask;
    logic [63:0] h;
    logic [63:0] folded;
    fh64_out_t   r;
    nb = (it.valid_bytes > 4'd8) ? 4'd8 : it.valid_bytes;
    mask = (nb == 4'd8) ? '1 : ((64'd1 << (nb * 8)) - 64'd1);
    if (!msg_open) acc_q = seed_q ^ ({32'd0, it.message_length} * HASH_MULT);
    if (nb != 4'd0) acc_q = (acc_q ^ fold_mix(it.word & mask)) * HASH_MULT;
    if (!it.last) begin
      msg_open = 1'b1;
    end else begin
      h = fold_mix(acc_q);
      folded = h - (h >> 32);
      r.hash64 = h;
      r.hash32 = folded[31:0];
      hash_q.push_back(r);
      msg_open = 1'b0;
    end
  endfunction

  function automatic fh64_in_t mk_item(logic [63:0] w, logic [3:0] vb, logic last_word,
                                       logic [31:0] len);
    fh64_in_t it;
    it.word           = w;
    it.valid_bytes    = vb;
    it.last           = last_word;
    it.message_length = len;
    return it;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(fh64_in_t it);
    int gap;
    @(negedge clk);
    src_valid = 1'b1;
    src_data  = it;
    do @(posedge clk); while (src_stall);
    absorb_word(it);
    items_sent++;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      src_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_message(int unsigned nbytes, logic [31:0] len_field);
    int       nwords;
    int       rem;
    fh64_in_t it;
    nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      rem = (i == nwords - 1) ? nbytes - 8 * i : 8;
      // length only counts on the opening word; scramble it elsewhere
      it = mk_item(rand64(), rem[3:0], i == nwords - 1, (i == 0) ? len_field : $urandom);
      send_item(it);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    src_valid = 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] value);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    seed_q = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    send_item(mk_item(rand64(), 4'd0, 1'b1, 32'd0));
    send_item(mk_item('1, 4'd0, 1'b1, 32'hFFFF_FFFF));
    send_item(mk_item('1, 4'd8, 1'b1, 32'd8));
    send_item(mk_item('0, 4'd8, 1'b1, 32'd8));
    for (int n = 1; n < 8; n++) send_item(mk_item('1, n[3:0], 1'b1, n));
    send_item(mk_item(rand64(), 4'd15, 1'b1, 32'd8));
    send_item(mk_item(rand64(), 4'd9, 1'b1, 32'd8));
    send_item(mk_item(rand64(), 4'd0, 1'b0, 32'd5));
    send_item(mk_item(rand64(), 4'd5, 1'b1, $urandom));
    send_item(mk_item(rand64(), 4'd8, 1'b0, 32'hFFFF_FFFF));
    send_item(mk_item(rand64(), 4'd8, 1'b1, 32'd0));
    send_item(mk_item(rand64(), 4'd8, 1'b1, 32'd0));
    send_message(20, 20);
    drain();
  endtask

  task automatic test_seed_values();
    logic [63:0] seeds[4];
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = 64'h8000_0000_0000_0000;
    seeds[3] = rand64();
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_message(0, 0);
      send_message(13, 13);
      send_message(8, 8);
    end
    drain();
  endtask

  task automatic test_seed_mid_message();
    write_seed(rand64());
    send_item(mk_item(rand64(), 4'd8, 1'b0, 32'd16));
    // new seed must not touch the open message
    write_seed(rand64());
    send_item(mk_item(rand64(), 4'd8, 1'b1, $urandom));
    send_message(3, 3);
    drain();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_message($urandom_range(0, 8), $urandom_range(0, 8));
    drain();
  endtask

  task automatic test_random();
    int             roll;
    int unsigned    nbytes;
    logic [31:0]    len_field;
    int             stop_at;
    int             next_seed_at;
    int             phase;
    stop_at      = items_sent + RANDOM_ITEMS;
    next_seed_at = items_sent + SEED_INTERVAL;
    phase        = 0;
    tx_gaps      = 1'b0;
    rx_gaps      = 1'b0;
    while (items_sent < stop_at) begin
      if (items_sent >= next_seed_at) begin
        write_seed(rand64());
        next_seed_at = items_sent + SEED_INTERVAL;
        phase++;
        tx_gaps = (phase % 3) != 2;
        rx_gaps = (phase % 3) != 1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) nbytes = $urandom_range(0, 24);
        else if (roll < 95) nbytes = $urandom_range(25, 64);
        else nbytes = $urandom_range(65, 255);
        len_field = ($urandom_range(0, 9) == 0) ? $urandom : nbytes;
        send_message(nbytes, len_field);
      end else begin
        send_item(mk_item(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          $urandom));
      end
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (rx_hold) begin
      dst_stall = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold   = 1'b0;
      dst_stall = 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      dst_stall = 1'b1;
    end else if (rx_gaps) begin
      rx_gap        = pick_gap();
      rx_stall_left = (rx_gap > 0) ? rx_gap - 1 : 0;
      dst_stall     = rx_gap > 0;
    end else begin
      dst_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall) begin
      if (hash_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected hash transfer: hash64=%h hash32=%h",
                   dst_data.hash64, dst_data.hash32);
      end else begin
        hash_exp = hash_q.pop_front();
        if (dst_data.hash64 !== hash_exp.hash64 || dst_data.hash32 !== hash_exp.hash32) begin
          errors++;
          if (errors <= 10)
            $display("hash mismatch: exp %h/%h got %h/%h", hash_exp.hash64,
                     hash_exp.hash32, dst_data.hash64, dst_data.hash32);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (dst_valid && !dst_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    src_valid     = 1'b0;
    src_data      = '0;
    dst_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    tx_gaps       = 1'b0;
    rx_gaps       = 1'b0;
    rx_hold       = 1'b0;
    rx_stall_left = 0;
    seed_q        = SEED_RESET;
    acc_q         = '0;
    msg_open      = 1'b0;
    errors        = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_seed_values();
    test_seed_mid_message();
    test_backpressure();
    test_random();

    if (errors == 0 && hash_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
